// ===== rtl/scm_pkg.sv =====
// Package for the stop confirmation monitor: item codes, status codes,
// configuration register indexes and the payload and configuration structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package scm_pkg;

  // Default width of the saturating diagnostic counters.
  localparam int SCM_COUNT_WIDTH = 32;

  // Reset values of the configuration registers.
  localparam logic [31:0] TIMEOUT_RESET   = 32'd1000;
  localparam logic [30:0] THRESHOLD_RESET = 31'd6554;
  localparam logic [15:0] QUIET_RESET     = 16'd3;

  // Kind of an input item.
  typedef enum logic [1:0] {
    CMD_ACK  = 2'd0,
    CMD_ODOM = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Reported status, in order of increasing code; the codes do not follow the status priority.
  typedef enum logic [1:0] {
    STATUS_PENDING   = 2'd0,
    STATUS_CONFIRMED = 2'd1,
    STATUS_REJECTED  = 2'd2,
    STATUS_TIMED_OUT = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PRODUCER_ID  = 3'd0,
    CFG_SEQUENCE     = 3'd1,
    CFG_ZERO_STAMP   = 3'd2,
    CFG_TIMEOUT      = 3'd3,
    CFG_LINEAR_THR   = 3'd4,
    CFG_ANGULAR_THR  = 3'd5,
    CFG_QUIET_NEEDED = 3'd6,
    CFG_ACK_ONLY     = 3'd7
  } cfg_idx_e;

  // Current contents of the configuration registers.
  typedef struct packed {
    logic [63:0] expected_producer_id;
    logic [63:0] expected_sequence;
    logic [63:0] zero_stamp_ns;
    logic [31:0] timeout_ticks;
    logic [30:0] linear_threshold;
    logic [30:0] angular_threshold;
    logic [15:0] quiet_needed;
    logic        ack_only_policy;
  } scm_cfg_t;

  // One input item.
  typedef struct packed {
    cmd_e               command;
    logic        [63:0] producer_id;
    logic        [63:0] sequence_req;
    logic               accepted;
    logic        [63:0] stamp_ns;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic               speeds_valid;
  } scm_item_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [15:0] quiet_count;
    logic [31:0] odometry_seen;
    logic [31:0] post_ack_seen;
    logic [31:0] stale_seen;
    logic [31:0] moving_seen;
    logic        ack_seen;
    logic        ack_accepted;
    logic [63:0] ack_stamp;
    logic [63:0] last_odom_stamp;
  } scm_result_t;

endpackage

`default_nettype wire

// ===== rtl/stop_confirmation_monitor.sv =====
// Stop confirmation monitor: input register, single-pass state update, result register.
// Throughput: one item per cycle while the output is not held; the input register takes a new item in the
// same cycle its predecessor moves into the result register.
// Reset clears all monitor state and counters and loads the configuration defaults.
// Depends on scm_pkg, scm_cfg_regs and scm_core.
`default_nettype none

module stop_confirmation_monitor
  import scm_pkg::*;
#(
  parameter int COUNT_WIDTH = SCM_COUNT_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire cfg_idx_e    cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  scm_item_t        item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output scm_result_t      result
);

  scm_cfg_t    cfg;
  scm_item_t   s1_item;
  logic        s1_valid;
  logic        out_free;
  logic        advance;
  scm_result_t result_next;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  scm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline control: the item moves on when the result register is free.
  assign out_free   = !result_valid || result_ready;
  assign advance    = s1_valid && out_free;
  assign item_ready = !s1_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  scm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .item        (s1_item),
    .result_next (result_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // The input side stalls only when both stages are full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (s1_valid && result_valid && !result_ready))
    else $error("input stalled while a stage was free");

  // An item in the input register reaches the result register when it is empty.
  a_item_moves_on: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !result_valid) |=> result_valid)
    else $error("item did not move to the result register");

  // A rejection is reported only with a matching ack that refused the zero.
  a_rejected_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.status != STATUS_REJECTED) ||
                      (result.ack_seen && !result.ack_accepted)))
    else $error("rejected status without a refusing ack");

  // Confirmation requires an accepted ack.
  a_confirmed_needs_ack: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STATUS_CONFIRMED)) |->
      (result.ack_seen && result.ack_accepted))
    else $error("confirmed status without an accepted ack");

endmodule

`default_nettype wire

// ===== rtl/scm_cfg_regs.sv =====
// Configuration register file of the stop confirmation monitor.
// Depends on scm_pkg for the register indexes and the configuration struct.
`default_nettype none

module scm_cfg_regs
  import scm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire cfg_idx_e    wr_index,
  input  wire logic [63:0] wr_data,
  output scm_cfg_t         cfg
);

  scm_cfg_t regs;

  // Registers take the low bits of the write data that fit their width.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_producer_id <= '0;
      regs.expected_sequence    <= '0;
      regs.zero_stamp_ns        <= '0;
      regs.timeout_ticks        <= TIMEOUT_RESET;
      regs.linear_threshold     <= THRESHOLD_RESET;
      regs.angular_threshold    <= THRESHOLD_RESET;
      regs.quiet_needed         <= QUIET_RESET;
      regs.ack_only_policy      <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_PRODUCER_ID:  regs.expected_producer_id <= wr_data;
        CFG_SEQUENCE:     regs.expected_sequence    <= wr_data;
        CFG_ZERO_STAMP:   regs.zero_stamp_ns        <= wr_data;
        CFG_TIMEOUT:      regs.timeout_ticks        <= wr_data[31:0];
        CFG_LINEAR_THR:   regs.linear_threshold     <= wr_data[30:0];
        CFG_ANGULAR_THR:  regs.angular_threshold    <= wr_data[30:0];
        CFG_QUIET_NEEDED: regs.quiet_needed         <= wr_data[15:0];
        CFG_ACK_ONLY:     regs.ack_only_policy      <= wr_data[0];
        default:          regs.ack_only_policy      <= regs.ack_only_policy;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== rtl/scm_core.sv =====
// Monitor state, its single-pass update for one item and the status that follows.
// Depends on scm_pkg for the item, result and configuration types.
`default_nettype none

module scm_core
  import scm_pkg::*;
#(
  parameter int COUNT_WIDTH = SCM_COUNT_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  scm_cfg_t       cfg,
  input  wire logic      advance,
  input  scm_item_t      item,
  output scm_result_t    result_next
);

  // Saturating increment of a diagnostic counter.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  logic                   ack_flag, ack_flag_next;
  logic                   accept_flag, accept_flag_next;
  logic [63:0]            ack_stamp_reg, ack_stamp_reg_next;
  logic [15:0]            quiet_reg, quiet_reg_next;
  logic [63:0]            qualified_stamp, qualified_stamp_next;
  logic [63:0]            observed_stamp, observed_stamp_next;
  logic [31:0]            elapsed_ticks, elapsed_ticks_next;
  logic [COUNT_WIDTH-1:0] odom_counter, odom_counter_next;
  logic [COUNT_WIDTH-1:0] post_ack_counter, post_ack_counter_next;
  logic [COUNT_WIDTH-1:0] stale_counter, stale_counter_next;
  logic [COUNT_WIDTH-1:0] moving_counter, moving_counter_next;

  logic ack_match;
  logic stale;
  logic moving;
  logic [63:0] odom_ext, post_ext, stale_ext, moving_ext;

  // Item qualifiers.
  assign ack_match = (item.producer_id == cfg.expected_producer_id) &&
                     (item.sequence_req == cfg.expected_sequence) &&
                     (item.stamp_ns > cfg.zero_stamp_ns);
  assign stale     = (item.stamp_ns == 64'd0) || (item.stamp_ns <= qualified_stamp);
  assign moving    = !item.speeds_valid ||
                     (item.linear_speed > $signed({1'b0, cfg.linear_threshold})) ||
                     (item.angular_speed > $signed({1'b0, cfg.angular_threshold}));

  // Next state for the item in the input register.
  always_comb begin
    ack_flag_next         = ack_flag;
    accept_flag_next      = accept_flag;
    ack_stamp_reg_next    = ack_stamp_reg;
    quiet_reg_next        = quiet_reg;
    qualified_stamp_next  = qualified_stamp;
    observed_stamp_next   = observed_stamp;
    elapsed_ticks_next    = elapsed_ticks;
    odom_counter_next     = odom_counter;
    post_ack_counter_next = post_ack_counter;
    stale_counter_next    = stale_counter;
    moving_counter_next   = moving_counter;
    case (item.command)
      CMD_ACK: begin
        if (ack_match) begin
          // A first ack or a change of acceptance restarts the quiet check.
          if (!ack_flag || (accept_flag != item.accepted)) begin
            quiet_reg_next       = '0;
            qualified_stamp_next = '0;
            ack_stamp_reg_next   = item.stamp_ns;
          end
          ack_flag_next    = 1'b1;
          accept_flag_next = item.accepted;
        end
      end
      CMD_ODOM: begin
        odom_counter_next   = sat_inc(odom_counter);
        observed_stamp_next = item.stamp_ns;
        if (ack_flag && accept_flag) begin
          post_ack_counter_next = sat_inc(post_ack_counter);
          if (stale) begin
            stale_counter_next = sat_inc(stale_counter);
          end else begin
            qualified_stamp_next = item.stamp_ns;
            if (moving) begin
              moving_counter_next = sat_inc(moving_counter);
              quiet_reg_next      = '0;
            end else if (quiet_reg < cfg.quiet_needed) begin
              quiet_reg_next = quiet_reg + 16'd1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (!(&elapsed_ticks)) begin
          elapsed_ticks_next = elapsed_ticks + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers change only when the item moves on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_flag         <= 1'b0;
      accept_flag      <= 1'b0;
      ack_stamp_reg    <= '0;
      quiet_reg        <= '0;
      qualified_stamp  <= '0;
      observed_stamp   <= '0;
      elapsed_ticks    <= '0;
      odom_counter     <= '0;
      post_ack_counter <= '0;
      stale_counter    <= '0;
      moving_counter   <= '0;
    end else if (advance) begin
      ack_flag         <= ack_flag_next;
      accept_flag      <= accept_flag_next;
      ack_stamp_reg    <= ack_stamp_reg_next;
      quiet_reg        <= quiet_reg_next;
      qualified_stamp  <= qualified_stamp_next;
      observed_stamp   <= observed_stamp_next;
      elapsed_ticks    <= elapsed_ticks_next;
      odom_counter     <= odom_counter_next;
      post_ack_counter <= post_ack_counter_next;
      stale_counter    <= stale_counter_next;
      moving_counter   <= moving_counter_next;
    end
  end

  // Counters are reported in their low 32 bits, zero-extended when narrower.
  assign odom_ext   = 64'(odom_counter_next);
  assign post_ext   = 64'(post_ack_counter_next);
  assign stale_ext  = 64'(stale_counter_next);
  assign moving_ext = 64'(moving_counter_next);

  // Status priority: rejected, timed out, confirmed, pending.
  always_comb begin
    if (ack_flag_next && !accept_flag_next) begin
      result_next.status = STATUS_REJECTED;
    end else if (elapsed_ticks_next >= cfg.timeout_ticks) begin
      result_next.status = STATUS_TIMED_OUT;
    end else if (ack_flag_next && accept_flag_next &&
                 (cfg.ack_only_policy || (quiet_reg_next >= cfg.quiet_needed))) begin
      result_next.status = STATUS_CONFIRMED;
    end else begin
      result_next.status = STATUS_PENDING;
    end
    result_next.quiet_count     = quiet_reg_next;
    result_next.odometry_seen   = odom_ext[31:0];
    result_next.post_ack_seen   = post_ext[31:0];
    result_next.stale_seen      = stale_ext[31:0];
    result_next.moving_seen     = moving_ext[31:0];
    result_next.ack_seen        = ack_flag_next;
    result_next.ack_accepted    = accept_flag_next;
    result_next.ack_stamp       = ack_stamp_reg_next;
    result_next.last_odom_stamp = observed_stamp_next;
  end

endmodule

`default_nettype wire
